// ===== src/spcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_pkg
// Shared types and constants for the sample packer chunk framer.
// ----------------------------------------------------------------------------
package spcf_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned HeadBytes = 12;
  localparam int unsigned WordBytes = WordBits / ByteBits;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CntBits = 4;
  localparam int unsigned SlotBits = 6;
  localparam int unsigned DivCntBits = 5;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegChunkTag = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegSampleTotal = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegBitsPerSample = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegSlotsPerWord = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegMsbFirst = 3'd4;

  // Request codes
  localparam logic ReqStart = 1'b0;
  localparam logic ReqSample = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [WordBits-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last_byte;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic load_head;
    logic exec_sample;
    logic shift_byte;
  } cmd_t;

  typedef struct packed {
    logic in_is_start;
    logic div_last;
    logic flush;
    logic byte_last;
  } status_t;

endpackage

// ===== src/spcf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_div
// Restoring divider, one quotient bit per cycle while step_i is high, 32-bit
// dividend by 6-bit divisor. Used to count words in a chunk.
// ----------------------------------------------------------------------------
module spcf_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 step_i,
  input  logic [spcf_pkg::WordBits-1:0]        dividend_i,
  input  logic [spcf_pkg::SlotBits-1:0]        divisor_i,
  output logic [spcf_pkg::WordBits-1:0]        quot_o,
  output logic [spcf_pkg::SlotBits-1:0]        rem_o,
  output logic                                 last_o
);

  logic [spcf_pkg::WordBits-1:0]   quot_q, quot_d;
  logic [spcf_pkg::SlotBits-1:0]   rem_q, rem_d;
  logic [spcf_pkg::DivCntBits-1:0] cnt_q, cnt_d;
  logic [spcf_pkg::SlotBits:0]     trial;
  logic                            fits;

  always_comb begin
    trial = {rem_q, quot_q[spcf_pkg::WordBits-1]};
    fits = trial >= {1'b0, divisor_i};
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (step_i) begin
      quot_d = {quot_q[spcf_pkg::WordBits-2:0], fits};
      rem_d = fits ? spcf_pkg::SlotBits'(trial - {1'b0, divisor_i})
                   : trial[spcf_pkg::SlotBits-1:0];
      cnt_d = cnt_q + spcf_pkg::DivCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
  end

  assign quot_o = quot_q;
  assign rem_o = rem_q;
  assign last_o = &cnt_q;

endmodule

// ===== src/spcf_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_dpath
// Datapath: configuration registers, word packing, chunk counters, head
// length computation and the byte emitter.
// ----------------------------------------------------------------------------
module spcf_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spcf_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [spcf_pkg::WordBits-1:0]        cfg_data_i,
  input  spcf_pkg::in_item_t                   in_data_i,
  input  spcf_pkg::cmd_t                       cmd_i,
  output spcf_pkg::status_t                    sts_o,
  output spcf_pkg::out_item_t                  out_data_o,
  input  logic                                 out_fire_i
);

  localparam int unsigned WB = spcf_pkg::WordBits;
  localparam int unsigned SB = spcf_pkg::SlotBits;
  localparam int unsigned PosBits = 2 * SB;

  // Configuration
  logic [WB-1:0] tag_q, total_q;
  logic [SB-1:0] bps_q, spw_q;
  logic          msb_q;

  // Chunk state
  logic [WB-1:0] accum_q, seen_q, value_q;
  logic [SB-1:0] slot_q;
  logic          open_q;

  // Emitter
  logic [spcf_pkg::HeadBytes*spcf_pkg::ByteBits-1:0] shift_q;
  logic [spcf_pkg::CntBits-1:0]                      cnt_q;
  logic                                              final_q;

  logic [SB-1:0]      spw_eff, slot_sel;
  logic               slot_ok, full, done;
  logic [PosBits-1:0] bit_pos;
  logic [WB-1:0]      mask, contrib, word_new, seen_next, nwords, length;
  logic [WB-1:0]      quot;
  logic [SB-1:0]      rem;
  logic               div_last;

  spcf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture),
    .step_i     (cmd_i.div_step),
    .dividend_i (total_q),
    .divisor_i  (spw_eff),
    .quot_o     (quot),
    .rem_o      (rem),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      total_q <= '0;
      bps_q <= SB'(8);
      spw_q <= SB'(4);
      msb_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spcf_pkg::RegChunkTag:      tag_q <= cfg_data_i;
        spcf_pkg::RegSampleTotal:   total_q <= cfg_data_i;
        spcf_pkg::RegBitsPerSample: bps_q <= cfg_data_i[SB-1:0];
        spcf_pkg::RegSlotsPerWord:  spw_q <= cfg_data_i[SB-1:0];
        spcf_pkg::RegMsbFirst:      msb_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Slot placement and mask
  always_comb begin
    spw_eff = (spw_q == '0) ? SB'(1) : spw_q;
    slot_ok = 1'b1;
    slot_sel = slot_q;
    if (msb_q) begin
      slot_ok = slot_q < spw_eff;
      slot_sel = spw_eff - SB'(1) - slot_q;
    end
    bit_pos = PosBits'(slot_sel) * PosBits'(bps_q);
    mask = (bps_q >= SB'(WB)) ? '1 : ((WB'(1) << bps_q[4:0]) - WB'(1));
    contrib = (slot_ok && bit_pos < PosBits'(WB))
            ? ((value_q & mask) << bit_pos[4:0]) : '0;
    word_new = accum_q | contrib;
    seen_next = seen_q + WB'(1);
    done = seen_next >= total_q;
    full = ({1'b0, slot_q} + (SB+1)'(1)) >= {1'b0, spw_eff};
    nwords = quot + WB'(rem != '0);
    length = {nwords[WB-3:0], 2'b00} + WB'(4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      seen_q <= '0;
      slot_q <= '0;
      open_q <= 1'b0;
      cnt_q <= '0;
      final_q <= 1'b0;
    end else begin
      if (cmd_i.load_head) begin
        accum_q <= '0;
        seen_q <= '0;
        slot_q <= '0;
        open_q <= total_q != '0;
        cnt_q <= spcf_pkg::CntBits'(spcf_pkg::HeadBytes);
        final_q <= total_q == '0;
      end else if (cmd_i.exec_sample && open_q) begin
        seen_q <= seen_next;
        if (full || done) begin
          accum_q <= '0;
          slot_q <= '0;
          cnt_q <= spcf_pkg::CntBits'(spcf_pkg::WordBytes);
          final_q <= done;
        end else begin
          accum_q <= word_new;
          slot_q <= slot_q + SB'(1);
        end
        if (done) begin
          open_q <= 1'b0;
        end
      end else if (cmd_i.shift_byte) begin
        cnt_q <= cnt_q - spcf_pkg::CntBits'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= in_data_i.sample_value;
    end
    if (cmd_i.load_head) begin
      shift_q <= {total_q, length, tag_q};
    end else if (cmd_i.exec_sample && open_q && (full || done)) begin
      shift_q <= {(2 * WB)'(0), word_new};
    end else if (cmd_i.shift_byte) begin
      shift_q <= shift_q >> spcf_pkg::ByteBits;
    end
  end

  always_comb begin
    sts_o.in_is_start = in_data_i.req_type == spcf_pkg::ReqStart;
    sts_o.div_last = div_last;
    sts_o.flush = open_q && (full || done);
    sts_o.byte_last = cnt_q == spcf_pkg::CntBits'(1);
    out_data_o.out_byte = shift_q[spcf_pkg::ByteBits-1:0];
    out_data_o.last_byte = final_q && (cnt_q == spcf_pkg::CntBits'(1));
  end

  // The final byte of a chunk always leaves the chunk closed
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire_i && out_data_o.last_byte |-> !open_q)
    else $error("final byte sent while chunk still open");

endmodule

// ===== src/spcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_ctrl
// Controller: sequences capture, word-count division, head load, sample
// packing and byte emission.
// ----------------------------------------------------------------------------
module spcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  spcf_pkg::status_t sts_i,
  output spcf_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StExec = 5'b00010,
    StDiv  = 5'b00100,
    StLoad = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire, out_fire;

  assign in_fire = in_valid_i && (state_q == StIdle);
  assign out_fire = (state_q == StEmit) && !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.in_is_start ? StDiv : StExec;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_head = 1'b1;
        state_d = StEmit;
      end
      StExec: begin
        cmd_o.exec_sample = 1'b1;
        state_d = sts_i.flush ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_fire) begin
          cmd_o.shift_byte = 1'b1;
          if (sts_i.byte_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != StIdle;
  assign out_valid_o = state_q == StEmit;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while bytes pending");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && sts_i.byte_last |=> !in_stall_o)
    else $error("no return to idle after last byte of transaction");

  a_div_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> $past(state_q) == StDiv && $past(sts_i.div_last))
    else $error("head loaded before division finished");

endmodule

// ===== src/sample_packer_chunk_framer.sv =====
`timescale 1ns / 1ps
// Sequence: a start transaction runs the division in StDiv, then StLoad, then emits 12 head bytes.
// A sample transaction runs the packing state StExec; a completed word then emits 4 bytes.
// Items are taken one at a time: the input stalls until the current transaction and its bytes
// are done, so output stalls hold the input as well.
// Reset: async active low; clears chunk state, loads register defaults (8 bits, 4 slots).
// ----------------------------------------------------------------------------
// sample_packer_chunk_framer
// Packs samples into 32-bit words and emits a tagged, length-prefixed chunk
// as a byte stream.
// ----------------------------------------------------------------------------
module sample_packer_chunk_framer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spcf_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [spcf_pkg::WordBits-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  spcf_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output spcf_pkg::out_item_t                  out_data_o
);

  spcf_pkg::cmd_t    cmd;
  spcf_pkg::status_t sts;

  spcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spcf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o),
    .out_fire_i (out_valid_o && !out_stall_i)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sample_packer_chunk_framer. A built-in packing
// model predicts the chunk byte stream, with head, words and last flags, for
// every accepted transaction. A monitor compares each byte leaving the block
// against the oldest predicted byte. Directed corner cases run first, then
// randomized chunk phases with random register settings, input bursts and
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [spcf_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [spcf_pkg::WordBits-1:0]   cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  spcf_pkg::in_item_t              in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  spcf_pkg::out_item_t             out_data_o;

  // Register mirror, reset values as in the block
  logic [31:0] tag_r = '0;
  logic [31:0] total_r = '0;
  logic [5:0]  bps_r = 6'd8;
  logic [5:0]  spw_r = 6'd4;
  logic        msb_r = 1'b0;

  // Packing state mirror
  logic [31:0] acc_r = '0;
  logic [31:0] seen_r = '0;
  logic [5:0]  slot_r = '0;
  logic        open_r = 1'b0;

  spcf_pkg::out_item_t pending_bytes[$];
  spcf_pkg::out_item_t want_b;

  int unsigned n_items = 0;
  int unsigned n_live = 0;
  int unsigned n_bytes = 0;
  int unsigned n_err = 0;
  int unsigned n_phases = 0;
  int unsigned burst_left = 0;

  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_mask = '0;

  sample_packer_chunk_framer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Push one 32-bit word as four little-endian bytes
  function automatic void queue_word_bytes(logic [31:0] w, logic fin);
    spcf_pkg::out_item_t b;
    for (int i = 0; i < 4; i++) begin
      b.out_byte = w[8*i +: 8];
      b.last_byte = fin && (i == 3);
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic void pack_and_frame(spcf_pkg::in_item_t it);
    logic [31:0] spw;
    logic [31:0] nwords;
    logic [31:0] slot;
    logic [31:0] mask;
    logic [31:0] shift;
    logic        in_word;
    logic        done;
    logic        full;
    spw = (spw_r == 6'd0) ? 32'd1 : {26'd0, spw_r};
    if (it.req_type == spcf_pkg::ReqStart) begin
      n_live++;
      nwords = total_r / spw + ((total_r % spw) != 0 ? 32'd1 : 32'd0);
      queue_word_bytes(tag_r, 1'b0);
      queue_word_bytes(32'd4 + 32'd4 * nwords, 1'b0);
      queue_word_bytes(total_r, total_r == 32'd0);
      acc_r = '0;
      seen_r = '0;
      slot_r = '0;
      open_r = (total_r != 32'd0);
    end else if (open_r) begin
      n_live++;
      slot = {26'd0, slot_r};
      in_word = 1'b1;
      if (msb_r) begin
        if (slot < spw) slot = spw - 32'd1 - slot;
        else in_word = 1'b0;
      end
      mask = (bps_r >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << bps_r) - 32'd1);
      shift = slot * {26'd0, bps_r};
      if (in_word && shift < 32'd32) acc_r = acc_r | ((it.sample_value & mask) << shift);
      seen_r = seen_r + 32'd1;
      done = (seen_r >= total_r);
      full = ({26'd0, slot_r} + 32'd1 >= spw);
      slot_r = slot_r + 6'd1;
      if (full || done) begin
        queue_word_bytes(acc_r, done);
        acc_r = '0;
        slot_r = '0;
      end
      if (done) open_r = 1'b0;
    end
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver back-pressure: switch between quiet, light, heavy and patterned stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
      stall_mask = 8'($urandom);
    end
    stall_left--;
    stall_mask = {stall_mask[6:0], stall_mask[7]};
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= stall_mask[0];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte transaction: out_byte %h last_byte %b",
               out_data_o.out_byte, out_data_o.last_byte);
        n_err++;
      end else begin
        want_b = pending_bytes.pop_front();
        n_bytes++;
        if (out_data_o.out_byte !== want_b.out_byte) begin
          $error("out_byte: expected %h, got %h", want_b.out_byte, out_data_o.out_byte);
          n_err++;
        end
        if (out_data_o.last_byte !== want_b.last_byte) begin
          $error("last_byte: expected %b, got %b", want_b.last_byte, out_data_o.last_byte);
          n_err++;
        end
      end
    end
  end

  task automatic send_item(input logic req, input logic [31:0] val);
    spcf_pkg::in_item_t it;
    int unsigned        gap;
    it.req_type = req;
    it.sample_value = val;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    n_items++;
    pack_and_frame(it);
  endtask

  // Hold the input idle until every predicted byte is out, then let the block settle
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [spcf_pkg::CfgIdxBits-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      spcf_pkg::RegChunkTag:      tag_r = val;
      spcf_pkg::RegSampleTotal:   total_r = val;
      spcf_pkg::RegBitsPerSample: bps_r = val[5:0];
      spcf_pkg::RegSlotsPerWord:  spw_r = val[5:0];
      spcf_pkg::RegMsbFirst:      msb_r = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_empty_chunk();
    // Reset registers give a zero count: head only, flagged last
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    drain_and_settle();
  endtask

  task automatic test_head_wrap();
    // Zero slots act as one; length wraps to zero
    write_reg(spcf_pkg::RegChunkTag, 32'hFFFF_FFFF);
    write_reg(spcf_pkg::RegSampleTotal, 32'hFFFF_FFFF);
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd0);
    send_item(spcf_pkg::ReqStart, 32'h0);
    drain_and_settle();
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd63);
    write_reg(spcf_pkg::RegSampleTotal, 32'd64);
    write_reg(spcf_pkg::RegChunkTag, 32'h5453_4554);
    send_item(spcf_pkg::ReqStart, 32'hFFFF_FFFF);
    drain_and_settle();
  endtask

  task automatic test_packing_corners();
    // Full-width samples, one per word; samples past the count are dropped
    write_reg(spcf_pkg::RegBitsPerSample, 32'd32);
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd1);
    write_reg(spcf_pkg::RegSampleTotal, 32'd2);
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    send_item(spcf_pkg::ReqSample, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'h1234_5678);
    drain_and_settle();
    // Zero sample width masks everything
    write_reg(spcf_pkg::RegBitsPerSample, 32'd0);
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd2);
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    drain_and_settle();
    // Oversized width acts as 32; reversed slot lands past bit 31
    write_reg(spcf_pkg::RegBitsPerSample, 32'd40);
    write_reg(spcf_pkg::RegMsbFirst, 32'd1);
    write_reg(spcf_pkg::RegSampleTotal, 32'd1);
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    drain_and_settle();
    // Fifth byte slot starts at bit 32 and is lost
    write_reg(spcf_pkg::RegBitsPerSample, 32'd8);
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd5);
    write_reg(spcf_pkg::RegMsbFirst, 32'd0);
    write_reg(spcf_pkg::RegSampleTotal, 32'd5);
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'h0000_0011);
    send_item(spcf_pkg::ReqSample, 32'h0000_0022);
    send_item(spcf_pkg::ReqSample, 32'h0000_0033);
    send_item(spcf_pkg::ReqSample, 32'h0000_0044);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    drain_and_settle();
  endtask

  task automatic test_restart_and_live_regs();
    write_reg(spcf_pkg::RegBitsPerSample, 32'd4);
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd8);
    write_reg(spcf_pkg::RegMsbFirst, 32'd1);
    write_reg(spcf_pkg::RegSampleTotal, 32'd3);
    // Restart discards the partial word
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'hAAAA_AAAA);
    send_item(spcf_pkg::ReqStart, 32'h0);
    send_item(spcf_pkg::ReqSample, 32'h5555_5555);
    drain_and_settle();
    // Shrink the word while the chunk is open: the current slot no longer fits
    write_reg(spcf_pkg::RegSlotsPerWord, 32'd1);
    send_item(spcf_pkg::ReqSample, 32'hFFFF_FFFF);
    send_item(spcf_pkg::ReqSample, 32'h0000_0009);
    drain_and_settle();
  endtask

  task automatic test_random_chunks();
    int unsigned shape;
    int unsigned n_smp;
    int unsigned spw_eff;
    logic [31:0] v;
    while (n_items < 440) begin
      drain_and_settle();
      n_phases++;
      if ($urandom_range(0, 3) != 0) write_reg(spcf_pkg::RegChunkTag, $urandom);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: v = 32'd0;
          1: v = 32'd32;
          2: v = $urandom_range(33, 63);
          3: v = 32'd1;
          default: v = $urandom_range(1, 32);
        endcase
        write_reg(spcf_pkg::RegBitsPerSample, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: v = 32'd0;
          1: v = 32'd32;
          2: v = 32'd63;
          3: v = $urandom_range(33, 62);
          4: v = $urandom_range(9, 31);
          default: v = $urandom_range(1, 8);
        endcase
        write_reg(spcf_pkg::RegSlotsPerWord, v);
      end
      if ($urandom_range(0, 3) != 0) write_reg(spcf_pkg::RegMsbFirst, $urandom_range(0, 1));
      spw_eff = (spw_r == 6'd0) ? 1 : spw_r;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: v = 32'd0;
          1: v = 32'hFFFF_FFFF;
          2: v = $urandom;
          default: v = $urandom_range(1, 3 * spw_eff + 4);
        endcase
        write_reg(spcf_pkg::RegSampleTotal, v);
      end
      n_smp = (total_r > 32'd48) ? 48 : total_r;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        // No start: continue whatever chunk is open, or get dropped
        repeat ($urandom_range(1, 6)) send_item(spcf_pkg::ReqSample, rand_sample());
      end else if (shape == 1) begin
        send_item(spcf_pkg::ReqStart, $urandom);
        repeat ($urandom_range(0, n_smp)) send_item(spcf_pkg::ReqSample, rand_sample());
        send_item(spcf_pkg::ReqStart, $urandom);
        repeat (n_smp) send_item(spcf_pkg::ReqSample, rand_sample());
      end else if (shape == 2) begin
        // Leave the chunk open across the next register change
        send_item(spcf_pkg::ReqStart, $urandom);
        repeat ($urandom_range(0, n_smp / 2)) send_item(spcf_pkg::ReqSample, rand_sample());
      end else begin
        send_item(spcf_pkg::ReqStart, $urandom);
        repeat (n_smp) send_item(spcf_pkg::ReqSample, rand_sample());
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(spcf_pkg::ReqSample, rand_sample());
        end
      end
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_chunk();
    test_head_wrap();
    test_packing_corners();
    test_restart_and_live_regs();
    test_random_chunks();
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_bytes.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      $error("%0d predicted bytes never came out", pending_bytes.size());
      n_err++;
    end
    $display("Covered %0d input transactions (%0d starts or live samples) in %0d phases",
             n_items, n_live, n_phases);
    $display("Compared %0d output bytes, %0d field mismatches or stray bytes", n_bytes, n_err);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/spcf_pkg.sv
src/spcf_div.sv
src/spcf_dpath.sv
src/spcf_ctrl.sv
src/sample_packer_chunk_framer.sv
bench/tb_top.sv
